@@ rtl/core/bfrp_pkg.sv @@
// Shared types and constants for the best-fit block reuse pool.
`timescale 1ns / 1ps

package bfrp_pkg;

    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;
    localparam int HELD_W      = 5;
    localparam int SLOTS_DEF   = 24;
    localparam int SLACK_DEF   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_DRAIN   = 2'd2
    } t_op;

    typedef enum logic {
        CFG_POOL_ENABLED = 1'b0,
        CFG_MAX_BYTES    = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAKE,
        ST_MOVE,
        ST_RELEASE,
        ST_DRAIN_RD,
        ST_DRAIN_OUT,
        ST_MISS
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] phys;
        logic [DATA_W-1:0] virt;
        logic [DATA_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] phys;
        logic [DATA_W-1:0] virt;
        logic [DATA_W-1:0] size;
        logic              must_free;
        logic              last;
        logic [HELD_W-1:0] entries;
        logic [DATA_W-1:0] bytes;
        logic [DATA_W-1:0] evictions;
    } t_result;

endpackage

@@ rtl/core/best_fit_block_reuse_pool_core.sv @@
// Top level of the best-fit block reuse pool: sequencer, counters and slot memory.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   i_op, i_size, i_phys_addr, i_virt_addr
//   output   out        o_out_valid / i_out_stall o_found .. o_evictions
//   config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An acquire is taken in the idle step and scans with one slot read per scan cycle, then
// lets the last read and its comparison finish and, on a hit, reads the last entry and
// writes it back into the taken slot. A release and a drain each go through their own steps,
// and a drain reads each held block before it is emitted. Reset is synchronous, active low,
// and resets the counters and the control state but not the slot memory or the captured item.
// A stalled output holds the sequencer at its result step; a new item is taken only in idle.
`timescale 1ns / 1ps

module best_fit_block_reuse_pool_core #(
    parameter int SLOTS        = bfrp_pkg::SLOTS_DEF,
    parameter int SLACK_FACTOR = bfrp_pkg::SLACK_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bfrp_pkg::OP_W-1:0]   i_op,
    input  logic [bfrp_pkg::DATA_W-1:0] i_size,
    input  logic [bfrp_pkg::DATA_W-1:0] i_phys_addr,
    input  logic [bfrp_pkg::DATA_W-1:0] i_virt_addr,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [bfrp_pkg::DATA_W-1:0] o_out_phys,
    output logic [bfrp_pkg::DATA_W-1:0] o_out_virt,
    output logic [bfrp_pkg::DATA_W-1:0] o_out_size,
    output logic                        o_must_free,
    output logic                        o_last,
    output logic [bfrp_pkg::HELD_W-1:0] o_entries_held,
    output logic [bfrp_pkg::DATA_W-1:0] o_bytes_held,
    output logic [bfrp_pkg::DATA_W-1:0] o_evictions,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [bfrp_pkg::DATA_W-1:0] i_cfg_data
);

    import bfrp_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int LIM_W = DATA_W + $clog2(SLACK_FACTOR + 1);
    localparam int ENT_W = $bits(t_entry);

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op;
    logic [DATA_W-1:0]   r_size, r_phys, r_virt;
    logic [LIM_W-1:0]    r_limit;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic                r_have, n_have;
    logic [IDX_W-1:0]    r_best_idx, n_best_idx;
    t_entry              r_best, n_best;
    logic [CNT_W-1:0]    r_drain_n, n_drain_n;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [DATA_W-1:0]   r_total, n_total;
    logic [DATA_W-1:0]   r_evict, n_evict;
    logic                r_pool_enabled;
    logic [DATA_W-1:0]   r_max_bytes;
    t_result             r_res, n_res;
    logic                r_out_valid;

    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    t_entry              mem_wr_data;
    logic [IDX_W-1:0]    mem_rd_addr;
    logic [ENT_W-1:0]    mem_rd_raw;
    t_entry              rd_entry;
    logic [IDX_W-1:0]    last_idx;
    logic                fit;
    logic                better;
    logic                rel_ok;
    logic                drain_last;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign rd_entry    = t_entry'(mem_rd_raw);
    assign last_idx    = IDX_W'(r_count - CNT_W'(1));

    assign fit    = r_pool_enabled && (rd_entry.size >= r_size)
                    && (LIM_W'(rd_entry.size) <= r_limit);
    assign better = !r_have || (rd_entry.size < r_best.size);
    assign rel_ok = r_pool_enabled && (r_count < CNT_W'(SLOTS))
                    && ({1'b0, r_total} + {1'b0, r_size} <= {1'b0, r_max_bytes});
    assign drain_last = ((r_idx + CNT_W'(1)) == r_drain_n);

    assign mem_rd_addr = (r_state == ST_TAKE || r_state == ST_MOVE) ? last_idx
                                                                    : r_idx[IDX_W-1:0];

    bfrp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_raw)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_cmp_idx   = r_cmp_idx;
        n_have      = r_have;
        n_best_idx  = r_best_idx;
        n_best      = r_best;
        n_drain_n   = r_drain_n;
        n_count     = r_count;
        n_total     = r_total;
        n_evict     = r_evict;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_best_idx;
        mem_wr_data = rd_entry;
        out_load    = 1'b0;
        n_res       = '0;
        n_res.last  = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_have = 1'b0;
                    case (i_op)
                        OP_ACQUIRE: n_state = ST_SCAN;
                        OP_RELEASE: n_state = ST_RELEASE;
                        OP_DRAIN: begin
                            n_drain_n = r_count;
                            n_count   = '0;
                            n_total   = '0;
                            n_state   = (r_count == '0) ? ST_MISS : ST_DRAIN_RD;
                        end
                        default: n_state = ST_MISS;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_pend && fit && better) begin
                    n_have     = 1'b1;
                    n_best_idx = r_cmp_idx;
                    n_best     = rd_entry;
                end
                if (r_idx < r_count) begin
                    n_idx     = r_idx + CNT_W'(1);
                    n_pend    = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = r_have ? ST_TAKE : ST_MISS;
                    end
                end
            end
            ST_TAKE: begin
                n_state = ST_MOVE;
            end
            ST_MOVE: begin
                if (out_free) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_best_idx;
                    mem_wr_data = rd_entry;
                    n_count     = r_count - CNT_W'(1);
                    n_total     = r_total - r_best.size;
                    out_load    = 1'b1;
                    n_res.found = 1'b1;
                    n_res.phys  = r_best.phys;
                    n_res.virt  = r_best.virt;
                    n_res.size  = r_best.size;
                    n_state     = ST_IDLE;
                end
            end
            ST_RELEASE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                    if (rel_ok) begin
                        mem_wr_en        = 1'b1;
                        mem_wr_addr      = r_count[IDX_W-1:0];
                        mem_wr_data.phys = r_phys;
                        mem_wr_data.virt = r_virt;
                        mem_wr_data.size = r_size;
                        n_count          = r_count + CNT_W'(1);
                        n_total          = r_total + r_size;
                        n_res.found      = 1'b1;
                    end else begin
                        n_evict         = r_evict + DATA_W'(1);
                        n_res.phys      = r_phys;
                        n_res.virt      = r_virt;
                        n_res.size      = r_size;
                        n_res.must_free = 1'b1;
                    end
                end
            end
            ST_DRAIN_RD: begin
                n_state = ST_DRAIN_OUT;
            end
            ST_DRAIN_OUT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    n_res.found     = 1'b1;
                    n_res.phys      = rd_entry.phys;
                    n_res.virt      = rd_entry.virt;
                    n_res.size      = rd_entry.size;
                    n_res.must_free = 1'b1;
                    n_res.last      = drain_last;
                    n_idx           = r_idx + CNT_W'(1);
                    n_state         = drain_last ? ST_IDLE : ST_DRAIN_RD;
                end
            end
            ST_MISS: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_res.entries   = HELD_W'(n_count);
        n_res.bytes     = n_total;
        n_res.evictions = n_evict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_idx          <= '0;
            r_pend         <= 1'b0;
            r_have         <= 1'b0;
            r_drain_n      <= '0;
            r_count        <= '0;
            r_total        <= '0;
            r_evict        <= '0;
            r_pool_enabled <= 1'b1;
            r_max_bytes    <= DATA_W'(16777216);
            r_out_valid    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_have    <= n_have;
            r_drain_n <= n_drain_n;
            r_count   <= n_count;
            r_total   <= n_total;
            r_evict   <= n_evict;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POOL_ENABLED: r_pool_enabled <= i_cfg_data[0];
                    CFG_MAX_BYTES:    r_max_bytes    <= i_cfg_data;
                    default:          r_max_bytes    <= r_max_bytes;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= i_op;
            r_size  <= i_size;
            r_phys  <= i_phys_addr;
            r_virt  <= i_virt_addr;
            r_limit <= LIM_W'(i_size) * LIM_W'(SLACK_FACTOR);
        end
        r_cmp_idx  <= n_cmp_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        if (out_load) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_res.found;
    assign o_out_phys     = r_res.phys;
    assign o_out_virt     = r_res.virt;
    assign o_out_size     = r_res.size;
    assign o_must_free    = r_res.must_free;
    assign o_last         = r_res.last;
    assign o_entries_held = r_res.entries;
    assign o_bytes_held   = r_res.bytes;
    assign o_evictions    = r_res.evictions;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("Held block count exceeds the slot count.");

    a_empty_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0))
        else $error("Empty pool holds a nonzero byte total.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("Sequencer did not leave idle after taking an item.");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_res.found && n_res.must_free) |-> (n_count == '0 && n_total == '0))
        else $error("Drained block reported with a nonempty pool.");

    a_op_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RELEASE) |-> (r_op == OP_RELEASE))
        else $error("Release step entered for an item that is not a release.");

endmodule

@@ rtl/core/bfrp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module bfrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ tb/tb_best_fit_block_reuse_pool_core.sv @@
// Self-checking testbench for the best-fit block reuse pool core, with an in-bench pool model.
`timescale 1ns / 1ps

module tb_best_fit_block_reuse_pool_core;
    import bfrp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [OP_W-1:0]   i_op;
    logic [DATA_W-1:0] i_size;
    logic [DATA_W-1:0] i_phys_addr;
    logic [DATA_W-1:0] i_virt_addr;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_found;
    logic [DATA_W-1:0] o_out_phys;
    logic [DATA_W-1:0] o_out_virt;
    logic [DATA_W-1:0] o_out_size;
    logic              o_must_free;
    logic              o_last;
    logic [HELD_W-1:0] o_entries_held;
    logic [DATA_W-1:0] o_bytes_held;
    logic [DATA_W-1:0] o_evictions;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_index;
    logic [DATA_W-1:0] i_cfg_data;

    best_fit_block_reuse_pool_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_size         (i_size),
        .i_phys_addr    (i_phys_addr),
        .i_virt_addr    (i_virt_addr),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_out_phys     (o_out_phys),
        .o_out_virt     (o_out_virt),
        .o_out_size     (o_out_size),
        .o_must_free    (o_must_free),
        .o_last         (o_last),
        .o_entries_held (o_entries_held),
        .o_bytes_held   (o_bytes_held),
        .o_evictions    (o_evictions),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    logic [DATA_W-1:0] held_phys [SLOTS_DEF];
    logic [DATA_W-1:0] held_virt [SLOTS_DEF];
    logic [DATA_W-1:0] held_size [SLOTS_DEF];
    int unsigned       held_n;
    logic [DATA_W-1:0] held_bytes;
    logic [DATA_W-1:0] evict_count;
    logic [DATA_W-1:0] cap_bytes;
    logic              pool_on;
    t_result           pool_due [$];

    int err_count;
    int cycle_count;
    int snd_gap_pct;
    int rcv_stall_pct;
    int hold_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        if (err_count < 40) begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want) begin
            report_error($sformatf("%s is %h, expected %h", name, got, want));
        end
    endtask

    task automatic pool_predict(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] size,
                                input logic [DATA_W-1:0] phys, input logic [DATA_W-1:0] virt);
        t_result         r;
        int              best;
        int              i;
        int unsigned     n;
        logic [DATA_W+4:0] limit;
        r = '0;
        r.last = 1'b1;
        n = 0;
        case (op)
            OP_ACQUIRE: begin
                best = -1;
                limit = (DATA_W+5)'(size) * (DATA_W+5)'(SLACK_DEF);
                if (pool_on) begin
                    for (i = 0; i < held_n; i++) begin
                        if (held_size[i] >= size && (DATA_W+5)'(held_size[i]) <= limit &&
                            (best < 0 || held_size[i] < held_size[best])) begin
                            best = i;
                        end
                    end
                end
                if (best >= 0) begin
                    r.found = 1'b1;
                    r.phys = held_phys[best];
                    r.virt = held_virt[best];
                    r.size = held_size[best];
                    held_bytes -= held_size[best];
                    held_n--;
                    held_phys[best] = held_phys[held_n];
                    held_virt[best] = held_virt[held_n];
                    held_size[best] = held_size[held_n];
                end
            end
            OP_RELEASE: begin
                if (pool_on && held_n < SLOTS_DEF &&
                    {1'b0, held_bytes} + {1'b0, size} <= {1'b0, cap_bytes}) begin
                    held_phys[held_n] = phys;
                    held_virt[held_n] = virt;
                    held_size[held_n] = size;
                    held_n++;
                    held_bytes += size;
                    r.found = 1'b1;
                end else begin
                    evict_count++;
                    r.must_free = 1'b1;
                    r.phys = phys;
                    r.virt = virt;
                    r.size = size;
                end
            end
            OP_DRAIN: begin
                n = held_n;
                held_n = 0;
                held_bytes = '0;
                for (i = 0; i < n; i++) begin
                    r.found = 1'b1;
                    r.phys = held_phys[i];
                    r.virt = held_virt[i];
                    r.size = held_size[i];
                    r.must_free = 1'b1;
                    r.last = (i == n - 1);
                    r.entries = '0;
                    r.bytes = '0;
                    r.evictions = evict_count;
                    pool_due.push_back(r);
                end
            end
            default: ;
        endcase
        if (n == 0) begin
            r.entries = HELD_W'(held_n);
            r.bytes = held_bytes;
            r.evictions = evict_count;
            pool_due.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pool_due.size() == 0) begin
                    report_error("result item with nothing outstanding");
                end else begin
                    want = pool_due.pop_front();
                    check_field("found", 32'(o_found), 32'(want.found));
                    check_field("out_phys", o_out_phys, want.phys);
                    check_field("out_virt", o_out_virt, want.virt);
                    check_field("out_size", o_out_size, want.size);
                    check_field("must_free", 32'(o_must_free), 32'(want.must_free));
                    check_field("last", 32'(o_last), 32'(want.last));
                    check_field("entries_held", 32'(o_entries_held), 32'(want.entries));
                    check_field("bytes_held", o_bytes_held, want.bytes);
                    check_field("evictions", o_evictions, want.evictions);
                end
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
            end
            i_out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[best_fit_block_reuse_pool_core] ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] size,
                             input logic [DATA_W-1:0] phys, input logic [DATA_W-1:0] virt);
        while ($urandom_range(0, 99) < snd_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_size      <= size;
        i_phys_addr <= phys;
        i_virt_addr <= virt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pool_predict(op, size, phys, virt);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pool_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [DATA_W-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_POOL_ENABLED: pool_on = data[0];
            CFG_MAX_BYTES:    cap_bytes = data;
            default: ;
        endcase
    endtask

    function automatic logic [DATA_W-1:0] rand_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            return '0;
        end else if (pick < 15) begin
            return $urandom;
        end
        return DATA_W'($urandom_range(1, 48) * 64);
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            return OP_RELEASE;
        end else if (pick < 84) begin
            return OP_ACQUIRE;
        end else if (pick < 95) begin
            return OP_DRAIN;
        end
        return OP_UNDEFINED;
    endfunction

    task automatic send_random(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            send_item(rand_op(), rand_size(), $urandom, $urandom);
        end
    endtask

    task automatic test_empty_pool();
        send_item(OP_DRAIN, '0, '0, '0);
        send_item(OP_ACQUIRE, '0, '0, '0);
        send_item(OP_UNDEFINED, '1, '1, '1);
    endtask

    task automatic test_best_fit();
        send_item(OP_RELEASE, 32'd100, '1, '0);
        send_item(OP_RELEASE, 32'd150, 32'h1000_0150, 32'h2000_0150);
        send_item(OP_RELEASE, 32'd60, 32'h1000_0060, 32'h2000_0060);
        send_item(OP_ACQUIRE, 32'd60, '0, '0);
        send_item(OP_ACQUIRE, 32'd80, '0, '0);
        send_item(OP_RELEASE, 32'd0, 32'h1000_0000, 32'h2000_0000);
        send_item(OP_ACQUIRE, 32'd0, '0, '0);
        send_item(OP_RELEASE, 32'd100, 32'h1000_0101, 32'h2000_0101);
        send_item(OP_RELEASE, 32'd100, 32'h1000_0102, 32'h2000_0102);
        send_item(OP_ACQUIRE, 32'd100, '0, '0);
        send_item(OP_ACQUIRE, 32'd1000, '0, '0);
        send_item(OP_DRAIN, '0, '0, '0);
    endtask

    task automatic test_byte_cap();
        write_reg(CFG_MAX_BYTES, '0);
        send_item(OP_RELEASE, 32'd0, '0, '1);
        send_item(OP_RELEASE, 32'd1, 32'h0000_0001, 32'h0000_0002);
        write_reg(CFG_MAX_BYTES, '1);
        send_item(OP_RELEASE, '1, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_item(OP_RELEASE, 32'd1, 32'h0000_0003, 32'h0000_0004);
        send_item(OP_ACQUIRE, 32'h8000_0000, '0, '0);
        send_item(OP_DRAIN, '0, '0, '0);
    endtask

    task automatic test_disabled_pool();
        send_item(OP_RELEASE, 32'd500, 32'h3000_0500, 32'h4000_0500);
        write_reg(CFG_POOL_ENABLED, 1'b0);
        send_item(OP_ACQUIRE, 32'd500, '0, '0);
        send_item(OP_RELEASE, 32'd600, 32'h3000_0600, 32'h4000_0600);
        send_item(OP_DRAIN, '0, '0, '0);
        write_reg(CFG_POOL_ENABLED, 1'b1);
    endtask

    task automatic test_backpressure();
        int k;
        hold_left = 400;
        for (k = 0; k < 30; k++) begin
            send_item(OP_RELEASE, DATA_W'($urandom_range(1, 64) * 32), $urandom, $urandom);
        end
        send_item(OP_DRAIN, '0, '0, '0);
        wait_drained();
    endtask

    task automatic test_random_phase(input int snd_pct, input int rcv_pct,
                                     input logic [DATA_W-1:0] cap, input int count);
        snd_gap_pct = snd_pct;
        rcv_stall_pct = rcv_pct;
        write_reg(CFG_MAX_BYTES, cap);
        send_random(count - 15);
        write_reg(CFG_POOL_ENABLED, 1'b0);
        send_random(15);
        write_reg(CFG_POOL_ENABLED, 1'b1);
    endtask

    initial begin
        err_count = 0;
        cycle_count = 0;
        hold_left = 0;
        snd_gap_pct = 10;
        rcv_stall_pct = 81;
        held_n = 0;
        held_bytes = '0;
        evict_count = '0;
        cap_bytes = 32'd16777216;
        pool_on = 1'b1;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_op        <= OP_ACQUIRE;
        i_size      <= '0;
        i_phys_addr <= '0;
        i_virt_addr <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_POOL_ENABLED;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pool();
        test_best_fit();
        test_byte_cap();
        test_disabled_pool();
        test_backpressure();
        test_random_phase(10, 81, DATA_W'($urandom_range(20000, 80000)), 125);
        test_random_phase(81, 10, '1, 125);
        test_random_phase(0, 0, $urandom, 125);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[best_fit_block_reuse_pool_core] OK");
        end else begin
            $display("[best_fit_block_reuse_pool_core] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bfrp_pkg.sv
rtl/core/bfrp_ram.sv
rtl/core/best_fit_block_reuse_pool_core.sv
tb/tb_best_fit_block_reuse_pool_core.sv
